>>> sv/sip_pkg.sv
package sip_pkg;

    localparam int CW     = 32;          // coordinate width
    localparam int FB     = 16;          // fraction bits
    localparam int EPS_W  = 17;          // tolerance register width
    localparam int DIF_W  = CW + 1;      // coordinate difference
    localparam int PRD_W  = 2 * DIF_W;   // cross product term
    localparam int DW     = PRD_W + 2;   // determinant and numerators
    localparam int QW     = FB + 2;      // quotient bits kept exactly
    localparam int PM_W   = DIF_W + QW + 1;
    localparam int SW     = PM_W + 1;
    localparam int NS     = QW + 7;      // pipeline register stages
    localparam int LATENCY = NS;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
    localparam logic [QW:0]      ONE       = (QW+1)'(1) << FB;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_NEAR_END = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

endpackage

>>> sv/segment_intersection_point.sv
// Segment crossing point, signed Q16.16.
//
// Input channel: the eight endpoint coordinates are transferred at a rising edge where
// start is high and busy is low. Busy never rises, so a new segment pair may be
// transferred in every cycle; the throughput is one pair per clock.
//
// Result channel: done is high for exactly one cycle with status, px and py. Each pair
// passes through every register stage named below before its result appears. Results
// leave in input order. The receiver cannot stall, and the pipeline never needs to hold off.
//
// Configuration: the epsilon tolerance is written through cfg_valid/cfg_ready with
// cfg_data. cfg_ready is always high. Write it only while no pair is in flight.
//
// The latency is set by the two parametric quotients: each is formed by a restoring
// divider with one stage per quotient bit (18 stages), running side by side.
// Ahead of them are difference, product, subtract and normalize stages; behind them are
// a status stage, the point multiply and the add and saturate stage.
//
// Reset (rst_n low, asynchronous) empties the pipeline and sets epsilon to 1.
module segment_intersection_point
    import sip_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [CW-1:0]    seg_a_start_x,
    input  logic signed [CW-1:0]    seg_a_start_y,
    input  logic signed [CW-1:0]    seg_a_end_x,
    input  logic signed [CW-1:0]    seg_a_end_y,
    input  logic signed [CW-1:0]    seg_b_start_x,
    input  logic signed [CW-1:0]    seg_b_start_y,
    input  logic signed [CW-1:0]    seg_b_end_x,
    input  logic signed [CW-1:0]    seg_b_end_y,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [EPS_W-1:0]        cfg_data,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [CW-1:0]    px,
    output logic signed [CW-1:0]    py
);

    // Values that ride along the whole pipeline for the final point.
    typedef struct packed {
        logic signed [DIF_W-1:0] a1;
        logic signed [DIF_W-1:0] b1;
        logic signed [CW-1:0]    asx;
        logic signed [CW-1:0]    asy;
    } side_t;

    // One divider stage carries both quotients.
    typedef struct packed {
        logic [DW-1:0] dm;
        logic [DW-1:0] r1;
        logic [DW-1:0] r2;
        logic [1:0]    lo1;
        logic [1:0]    lo2;
        logic [QW-1:0] q1;
        logic [QW-1:0] q2;
        logic          big1;
        logic          big2;
        logic          s1;
        logic          s2;
        logic          par;
    } div_t;

    localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic [EPS_W-1:0] eps_reg;
    logic [NS-1:0]    valid_reg;
    side_t            side_reg [NS];

    // Stage 1: differences.
    logic signed [DIF_W-1:0] a12_reg, b12_reg, a2_reg, b2_reg;
    // Stage 2: products.
    logic signed [PRD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    // Stage 3: determinant and numerators.
    logic signed [DW-1:0]    d_reg, n1_reg, n2_reg;
    // Stage 4 and the divider stages.
    div_t                    div_reg [QW+1];
    div_t                    div_next [QW+1];
    // Status, multiply and output stages.
    logic [1:0]              st_reg, st2_reg;
    logic [QW-1:0]           t_reg;
    logic signed [PM_W-1:0]  mx_reg, my_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg   <= EPS_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
            valid_reg <= {valid_reg[NS-2:0], start && !busy};
        end
    end

    // Stage 1.
    always_ff @(posedge clk)
    begin
        side_reg[0].a1  <= DIF_W'(seg_a_end_x) - DIF_W'(seg_a_start_x);
        side_reg[0].b1  <= DIF_W'(seg_a_end_y) - DIF_W'(seg_a_start_y);
        side_reg[0].asx <= seg_a_start_x;
        side_reg[0].asy <= seg_a_start_y;
        a12_reg <= DIF_W'(seg_b_start_x) - DIF_W'(seg_a_start_x);
        b12_reg <= DIF_W'(seg_b_start_y) - DIF_W'(seg_a_start_y);
        a2_reg  <= DIF_W'(seg_b_end_x) - DIF_W'(seg_b_start_x);
        b2_reg  <= DIF_W'(seg_b_end_y) - DIF_W'(seg_b_start_y);
        for (int i = 1; i < NS; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Stages 2 and 3: six 33 by 33 products, then the three cross differences.
    always_ff @(posedge clk)
    begin
        p0_reg <= PRD_W'(a2_reg) * PRD_W'(side_reg[0].b1);
        p1_reg <= PRD_W'(side_reg[0].a1) * PRD_W'(b2_reg);
        p2_reg <= PRD_W'(a2_reg) * PRD_W'(b12_reg);
        p3_reg <= PRD_W'(a12_reg) * PRD_W'(b2_reg);
        p4_reg <= PRD_W'(side_reg[0].a1) * PRD_W'(b12_reg);
        p5_reg <= PRD_W'(a12_reg) * PRD_W'(side_reg[0].b1);
        d_reg  <= DW'(p0_reg) - DW'(p1_reg);
        n1_reg <= DW'(p2_reg) - DW'(p3_reg);
        n2_reg <= DW'(p4_reg) - DW'(p5_reg);
    end

    // Stage 4 normalizes the determinant to be positive and splits each numerator into
    // sign and magnitude. Only 18 quotient bits are formed: any quotient of 2^18 or more
    // is both far from the endpoints and outside, so a flag stands for it.
    logic signed [DW-1:0] n1s, n2s;
    logic [DW-1:0]        dm, nm1, nm2;
    logic [DW:0]          rt1 [QW];
    logic [DW:0]          rt2 [QW];

    always_comb
    begin
        dm  = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
        n1s = d_reg[DW-1] ? -n1_reg : n1_reg;
        n2s = d_reg[DW-1] ? -n2_reg : n2_reg;
        nm1 = n1s[DW-1] ? DW'(-n1s) : DW'(n1s);
        nm2 = n2s[DW-1] ? DW'(-n2s) : DW'(n2s);

        div_next[0].dm   = dm;
        div_next[0].r1   = nm1 >> 2;
        div_next[0].r2   = nm2 >> 2;
        div_next[0].lo1  = nm1[1:0];
        div_next[0].lo2  = nm2[1:0];
        div_next[0].q1   = '0;
        div_next[0].q2   = '0;
        div_next[0].big1 = {2'b00, nm1} >= {dm, 2'b00};
        div_next[0].big2 = {2'b00, nm2} >= {dm, 2'b00};
        div_next[0].s1   = n1s[DW-1];
        div_next[0].s2   = n2s[DW-1];
        div_next[0].par  = (dm == '0) || (dm < (DW'(eps_reg) << FB));

        // Divider: each stage brings in one numerator bit and settles one quotient bit.
        for (int k = 0; k < QW; k++)
        begin
            div_next[k+1]     = div_reg[k];
            rt1[k]            = {div_reg[k].r1, div_reg[k].lo1[1]};
            rt2[k]            = {div_reg[k].r2, div_reg[k].lo2[1]};
            div_next[k+1].lo1 = {div_reg[k].lo1[0], 1'b0};
            div_next[k+1].lo2 = {div_reg[k].lo2[0], 1'b0};
            if (rt1[k] >= {1'b0, div_reg[k].dm})
            begin
                div_next[k+1].r1 = DW'(rt1[k] - {1'b0, div_reg[k].dm});
                div_next[k+1].q1 = {div_reg[k].q1[QW-2:0], 1'b1};
            end
            else
            begin
                div_next[k+1].r1 = rt1[k][DW-1:0];
                div_next[k+1].q1 = {div_reg[k].q1[QW-2:0], 1'b0};
            end
            if (rt2[k] >= {1'b0, div_reg[k].dm})
            begin
                div_next[k+1].r2 = DW'(rt2[k] - {1'b0, div_reg[k].dm});
                div_next[k+1].q2 = {div_reg[k].q2[QW-2:0], 1'b1};
            end
            else
            begin
                div_next[k+1].r2 = rt2[k][DW-1:0];
                div_next[k+1].q2 = {div_reg[k].q2[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= QW; k++)
        begin
            div_reg[k] <= div_next[k];
        end
    end

    function automatic logic near_end(logic [QW-1:0] q, logic s, logic big,
                                      logic [EPS_W-1:0] eps);
        logic [QW:0] qe;
        logic [QW:0] dist_one;
        qe = {1'b0, q};
        if (s)
        begin
            dist_one = qe + ONE;
        end
        else if (qe >= ONE)
        begin
            dist_one = qe - ONE;
        end
        else
        begin
            dist_one = ONE - qe;
        end
        return !big && ((qe < (QW+1)'(eps)) || (dist_one < (QW+1)'(eps)));
    endfunction

    function automatic logic outside(logic [QW-1:0] q, logic s, logic big);
        return big || (s && (q != '0)) || ({1'b0, q} > ONE);
    endfunction

    // Status stage, in the order parallel, near an endpoint, outside.
    logic [1:0] st_next;
    div_t       dv;

    always_comb
    begin
        dv = div_reg[QW];
        if (dv.par)
        begin
            st_next = ST_PARALLEL;
        end
        else if (near_end(dv.q1, dv.s1, dv.big1, eps_reg)
                 || near_end(dv.q2, dv.s2, dv.big2, eps_reg))
        begin
            st_next = ST_NEAR_END;
        end
        else if (outside(dv.q1, dv.s1, dv.big1) || outside(dv.q2, dv.s2, dv.big2))
        begin
            st_next = ST_OUTSIDE;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    // Point: start + floor(delta * t1 / 2^FB), saturated; zero when rejected.
    logic signed [SW-1:0] sx, sy;

    always_comb
    begin
        sx = SW'(side_reg[QW+5].asx) + SW'(mx_reg >>> FB);
        sy = SW'(side_reg[QW+5].asy) + SW'(my_reg >>> FB);
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        t_reg   <= (st_next == ST_OK) ? dv.q1 : '0;
        st2_reg <= st_reg;
        mx_reg  <= PM_W'(side_reg[QW+4].a1) * $signed({1'b0, t_reg});
        my_reg  <= PM_W'(side_reg[QW+4].b1) * $signed({1'b0, t_reg});
        status  <= st2_reg;
        if (st2_reg != ST_OK)
        begin
            px <= '0;
            py <= '0;
        end
        else
        begin
            px <= (sx > MAXV) ? CW'(MAXV) : (sx < MINV) ? CW'(MINV) : CW'(sx);
            py <= (sy > MAXV) ? CW'(MAXV) : (sy < MINV) ? CW'(MINV) : CW'(sy);
        end
    end

endmodule

>>> sv/sip_checker.sv
module sip_checker
    import sip_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [1:0]           status,
    input logic signed [CW-1:0] px,
    input logic signed [CW-1:0] py
);

    // Every transfer in produces exactly one result after the fixed latency.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after input transfer");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching input transfer");

    // A rejected pair reports the origin.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((px == '0) && (py == '0)))
        else $error("nonzero point on rejected pair");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .px     (px),
    .py     (py)
);
